FILE: rtl/websocket_frame_deframer_core_assert.svh
// Assertion macros for the checker file.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define WSFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define WSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/wsfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsfd_pkg;

	localparam int unsigned LEN_W = 63;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	localparam logic [LEN_W-1:0] EXT16_BYTES = LEN_W'(2);
	localparam logic [LEN_W-1:0] EXT64_BYTES = LEN_W'(8);
	localparam logic [LEN_W-1:0] KEY_BYTES   = LEN_W'(4);

	typedef struct packed {
		logic [7:0]       data;
		logic             fin;
		logic [3:0]       opcode;
		logic             masked;
		logic [LEN_W-1:0] length;
		logic             last;
		logic             empty;
	} wsfd_result_t;

endpackage

`default_nettype wire

FILE: rtl/wsfd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module wsfd_parser
	import wsfd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [7:0]   rx_byte,
	output logic              res_valid,
	output wsfd_result_t      res
);

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXTLEN,
		PH_KEY,
		PH_PAYLOAD
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] cnt_q, cnt_d;
	logic [31:0]      key_q, key_d;
	logic             fin_q, fin_d;
	logic [3:0]       opc_q, opc_d;
	logic             mask_q, mask_d;

	always_comb begin
		logic [6:0]       code;
		logic [LEN_W-1:0] cnt_dec;
		logic [LEN_W-1:0] cnt_inc;
		logic [7:0]       key_byte;
		logic             len_done;
		logic             hdr_done;

		phase_d   = phase_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		key_d     = key_q;
		fin_d     = fin_q;
		opc_d     = opc_q;
		mask_d    = mask_q;
		code      = rx_byte[6:0];
		cnt_dec   = (cnt_q == '0) ? '0 : cnt_q - LEN_W'(1);
		cnt_inc   = cnt_q + LEN_W'(1);
		key_byte  = key_q[31:24];
		len_done  = 1'b0;
		hdr_done  = 1'b0;
		res_valid = 1'b0;
		res       = '0;

		case (phase_q)
			PH_HDR1: begin
				mask_d = rx_byte[7];
				len_d  = '0;
				if (code == LEN_CODE_16) begin
					cnt_d   = EXT16_BYTES;
					phase_d = PH_EXTLEN;
				end else if (code == LEN_CODE_64) begin
					cnt_d   = EXT64_BYTES;
					phase_d = PH_EXTLEN;
				end else begin
					len_d    = LEN_W'(code);
					len_done = 1'b1;
				end
			end
			PH_EXTLEN: begin
				len_d = {len_q[LEN_W-9:0], rx_byte};
				cnt_d = cnt_dec;
				if (cnt_dec == '0) begin
					len_done = 1'b1;
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], rx_byte};
				cnt_d = cnt_dec;
				if (cnt_dec == '0) begin
					hdr_done = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				case (cnt_q[1:0])
					2'd0: key_byte = key_q[31:24];
					2'd1: key_byte = key_q[23:16];
					2'd2: key_byte = key_q[15:8];
					default: key_byte = key_q[7:0];
				endcase
				cnt_d     = cnt_inc;
				res_valid = 1'b1;
				res.data  = mask_q ? (rx_byte ^ key_byte) : rx_byte;
				res.last  = (cnt_inc >= len_q);
				if (res.last) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				fin_d   = rx_byte[7];
				opc_d   = rx_byte[3:0];
				phase_d = PH_HDR1;
			end
		endcase

		if (len_done) begin
			if (mask_d) begin
				key_d   = '0;
				cnt_d   = KEY_BYTES;
				phase_d = PH_KEY;
			end else begin
				hdr_done = 1'b1;
			end
		end

		if (hdr_done) begin
			if (len_d == '0) begin
				res_valid = 1'b1;
				res.data  = '0;
				res.last  = 1'b1;
				res.empty = 1'b1;
				phase_d   = PH_HDR0;
			end else begin
				cnt_d   = '0;
				phase_d = PH_PAYLOAD;
			end
		end

		res.fin    = fin_d;
		res.opcode = opc_d;
		res.masked = mask_d;
		res.length = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			len_q   <= '0;
			cnt_q   <= '0;
			key_q   <= '0;
			fin_q   <= 1'b0;
			opc_q   <= '0;
			mask_q  <= 1'b0;
		end else if (en) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			key_q   <= key_d;
			fin_q   <= fin_d;
			opc_q   <= opc_d;
			mask_q  <= mask_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/websocket_frame_deframer_core.sv
// Channel   Direction  Handshake             Payload
// rx        in         rx_valid / rx_ready   rx_byte
// out       out        out_valid / out_ready out_byte, frame_fin, frame_opcode,
//                                            was_masked, frame_length, is_last,
//                                            empty_frame
//
// One byte a cycle sustained while out is not stalled; a request passes from rx to out
// through the input register, then header/unmask logic into the result register.
// Header and key bytes produce nothing, but the last one of an empty frame yields its
// empty-frame marker as one request; each payload byte produces one request.
// Reset returns the parser to the first header byte and empties both stages.
// A stall on out holds the result register and, through it, the input stage.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_core
	import wsfd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rx_valid,
	output logic                  rx_ready,
	input  wire logic [7:0]       rx_byte,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            out_byte,
	output logic                  frame_fin,
	output logic [3:0]            frame_opcode,
	output logic                  was_masked,
	output logic [LEN_W-1:0]      frame_length,
	output logic                  is_last,
	output logic                  empty_frame
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         valid_s2;
	wsfd_result_t res_s2;
	logic         adv;
	logic         res_valid;
	wsfd_result_t res;

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign rx_ready = !valid_s1 || adv;

	wsfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rx_ready) begin
				valid_s1 <= rx_valid;
			end
			if (adv && res_valid) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
		if (adv && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign out_byte     = res_s2.data;
	assign frame_fin    = res_s2.fin;
	assign frame_opcode = res_s2.opcode;
	assign was_masked   = res_s2.masked;
	assign frame_length = res_s2.length;
	assign is_last      = res_s2.last;
	assign empty_frame  = res_s2.empty;

endmodule

`default_nettype wire

FILE: rtl/wsfd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "websocket_frame_deframer_core_assert.svh"

module wsfd_checker
	import wsfd_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [7:0]       out_byte,
	input wire logic [LEN_W-1:0] frame_length,
	input wire logic             is_last,
	input wire logic             empty_frame
);

	`WSFD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(frame_length) && $stable(is_last))

	`WSFD_ASSERT_IMPL(a_empty_marker, clk, arst_n, out_valid && empty_frame, is_last && (out_byte == 8'd0) && (frame_length == '0))

	`WSFD_ASSERT_IMPL(a_payload_len, clk, arst_n, out_valid && !empty_frame, frame_length != '0)

endmodule

bind websocket_frame_deframer_core wsfd_checker u_wsfd_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_websocket_frame_deframer_core.sv
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_core;
	import wsfd_pkg::*;

	typedef enum logic [2:0] {
		PS_HDR0,
		PS_HDR1,
		PS_EXTLEN,
		PS_KEY,
		PS_PAYLOAD
	} parse_state_t;

	typedef enum int {
		FORM_SHORT,
		FORM_EXT16,
		FORM_EXT64
	} len_form_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_valid = 1'b0;
	logic rx_ready;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_byte;
	logic frame_fin;
	logic [3:0] frame_opcode;
	logic was_masked;
	logic [LEN_W-1:0] frame_length;
	logic is_last;
	logic empty_frame;

	websocket_frame_deframer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.frame_fin(frame_fin),
		.frame_opcode(frame_opcode),
		.was_masked(was_masked),
		.frame_length(frame_length),
		.is_last(is_last),
		.empty_frame(empty_frame)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	logic [7:0] pending_bytes[$];
	wsfd_result_t expected_bytes[$];
	int mismatch_count = 0;
	int tx_gap = 0;
	bit tx_calm = 1'b0;
	int rx_stall = 0;
	bit rx_calm = 1'b0;

	parse_state_t ps_state = PS_HDR0;
	logic ps_fin = 1'b0;
	logic [3:0] ps_opcode = 4'h0;
	logic ps_masked = 1'b0;
	logic [LEN_W-1:0] ps_len = '0;
	logic [31:0] ps_key = 32'h0;
	logic [LEN_W-1:0] ps_count = '0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatch_count < 40)
			$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	function automatic logic header_done();
		if (ps_len == '0) begin
			ps_state = PS_HDR0;
			return 1'b1;
		end
		ps_count = '0;
		ps_state = PS_PAYLOAD;
		return 1'b0;
	endfunction

	function automatic logic length_done();
		if (ps_masked) begin
			ps_key = 32'h0;
			ps_count = KEY_BYTES;
			ps_state = PS_KEY;
			return 1'b0;
		end
		return header_done();
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		wsfd_result_t r;
		logic marker;
		int sel;
		marker = 1'b0;
		r = '0;
		case (ps_state)
			PS_HDR1: begin
				ps_masked = b[7];
				ps_len = '0;
				if (b[6:0] == LEN_CODE_16) begin
					ps_count = EXT16_BYTES;
					ps_state = PS_EXTLEN;
				end else if (b[6:0] == LEN_CODE_64) begin
					ps_count = EXT64_BYTES;
					ps_state = PS_EXTLEN;
				end else begin
					ps_len = LEN_W'(b[6:0]);
					marker = length_done();
				end
			end
			PS_EXTLEN: begin
				ps_len = {ps_len[LEN_W-9:0], b};
				if (ps_count != '0)
					ps_count = ps_count - 1'b1;
				if (ps_count == '0)
					marker = length_done();
			end
			PS_KEY: begin
				ps_key = {ps_key[23:0], b};
				if (ps_count != '0)
					ps_count = ps_count - 1'b1;
				if (ps_count == '0)
					marker = header_done();
			end
			PS_PAYLOAD: begin
				sel = int'(ps_count[1:0]);
				r.data = ps_masked ? (b ^ ps_key[31 - 8 * sel -: 8]) : b;
				ps_count = ps_count + 1'b1;
				r.last = (ps_count >= ps_len);
				r.fin = ps_fin;
				r.opcode = ps_opcode;
				r.masked = ps_masked;
				r.length = ps_len;
				expected_bytes = {expected_bytes, r};
				if (r.last)
					ps_state = PS_HDR0;
			end
			default: begin
				ps_fin = b[7];
				ps_opcode = b[3:0];
				ps_state = PS_HDR1;
			end
		endcase
		if (marker) begin
			r.fin = ps_fin;
			r.opcode = ps_opcode;
			r.masked = ps_masked;
			r.length = ps_len;
			r.last = 1'b1;
			r.empty = 1'b1;
			expected_bytes = {expected_bytes, r};
		end
	endfunction

	task automatic queue_frame(input logic [7:0] head, input logic masked,
			input len_form_t form, input logic [LEN_W-1:0] len, input logic top,
			input logic [31:0] key);
		logic [63:0] full;
		full = {top, len};
		pending_bytes = {pending_bytes, head};
		case (form)
			FORM_EXT16: begin
				pending_bytes = {pending_bytes, {masked, LEN_CODE_16}};
				pending_bytes = {pending_bytes, full[15:8]};
				pending_bytes = {pending_bytes, full[7:0]};
			end
			FORM_EXT64: begin
				pending_bytes = {pending_bytes, {masked, LEN_CODE_64}};
				for (int i = 7; i >= 0; i--)
					pending_bytes = {pending_bytes, full[8 * i +: 8]};
			end
			default: pending_bytes = {pending_bytes, {masked, len[6:0]}};
		endcase
		if (masked)
			for (int i = 3; i >= 0; i--)
				pending_bytes = {pending_bytes, key[8 * i +: 8]};
		for (longint i = 0; i < longint'(len); i++)
			pending_bytes = {pending_bytes, 8'($urandom)};
	endtask

	task automatic drain_all();
		while (pending_bytes.size() != 0 || rx_valid)
			@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
		end else begin
			if (rx_valid && rx_ready)
				deframe_byte(rx_byte);
			if (!rx_valid || rx_ready) begin
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
					rx_valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					rx_valid <= 1'b1;
					rx_byte <= pending_bytes.pop_front();
					tx_gap <= tx_calm ? 0 : $urandom_range(0, 6);
					if ($urandom_range(0, 149) == 0)
						tx_calm <= !tx_calm;
				end else begin
					rx_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_stall <= 0;
		end else if (out_ready && out_valid) begin
			if (!rx_calm) begin
				rx_stall <= $urandom_range(0, 6);
				if ($urandom_range(0, 6) != 0)
					out_ready <= 1'b0;
			end
			if ($urandom_range(0, 99) == 0)
				rx_calm <= !rx_calm;
		end else if (!out_ready) begin
			if (rx_stall <= 1)
				out_ready <= 1'b1;
			rx_stall <= rx_stall - 1;
		end
	end

	always @(posedge clk) begin : out_monitor
		wsfd_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected request", {56'h0, out_byte}, 64'h0);
			end else begin
				want = expected_bytes.pop_front();
				if (out_byte !== want.data)
					report_mismatch("out_byte", 64'(out_byte), 64'(want.data));
				if (frame_fin !== want.fin)
					report_mismatch("frame_fin", 64'(frame_fin), 64'(want.fin));
				if (frame_opcode !== want.opcode)
					report_mismatch("frame_opcode", 64'(frame_opcode),
						64'(want.opcode));
				if (was_masked !== want.masked)
					report_mismatch("was_masked", 64'(was_masked), 64'(want.masked));
				if (frame_length !== want.length)
					report_mismatch("frame_length", 64'(frame_length),
						64'(want.length));
				if (is_last !== want.last)
					report_mismatch("is_last", 64'(is_last), 64'(want.last));
				if (empty_frame !== want.empty)
					report_mismatch("empty_frame", 64'(empty_frame), 64'(want.empty));
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin : stimulus
		int total;
		int pick;
		int queued_n;
		logic [LEN_W-1:0] len;
		len_form_t form;
		bit paused;
		total = 0;
		paused = 1'b0;
		while (!arst_n)
			@(posedge clk);

		// empty frames ending on the length byte, the extended length and the key
		queue_frame(8'h81, 1'b0, FORM_SHORT, '0, 1'b0, 32'h0);
		queue_frame(8'h0F, 1'b0, FORM_EXT16, '0, 1'b0, 32'h0);
		queue_frame(8'h80, 1'b1, FORM_SHORT, '0, 1'b0, 32'hFF00AA55);
		// non-minimal 64-bit length with the top bit set
		queue_frame(8'h02, 1'b0, FORM_EXT64, LEN_W'(1), 1'b1, 32'h0);
		queue_frame(8'h8A, 1'b1, FORM_SHORT, LEN_W'(2), 1'b0, 32'h00FF55AA);
		drain_all();

		while (total < 1100) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				len = '0;
			else if (pick < 70)
				len = LEN_W'($urandom_range(1, 20));
			else if (pick < 88)
				len = LEN_W'($urandom_range(21, 125));
			else
				len = LEN_W'($urandom_range(0, 300));
			pick = $urandom_range(0, 99);
			if (len < 126 && pick < 70)
				form = FORM_SHORT;
			else if (pick < 85)
				form = FORM_EXT16;
			else
				form = FORM_EXT64;
			queued_n = pending_bytes.size();
			queue_frame(8'($urandom), 1'($urandom), form, len, 1'($urandom), $urandom);
			total += pending_bytes.size() - queued_n;
			if (!paused && total > 550) begin
				// hold until every request is out
				drain_all();
				paused = 1'b1;
			end
		end

		// largest 64-bit length, left open
		pending_bytes = {pending_bytes, 8'h01};
		pending_bytes = {pending_bytes, {1'b0, LEN_CODE_64}};
		repeat (8) pending_bytes = {pending_bytes, 8'hFF};
		repeat (12) pending_bytes = {pending_bytes, 8'($urandom)};

		drain_all();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_bytes.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
